### rtl/core/itda_pkg.sv
`default_nettype none

package itda_pkg;

   localparam int unsigned WordWidth  = 32;
   localparam int unsigned CharWidth  = 8;
   localparam int unsigned DigitCount = 10;
   localparam int unsigned BcdWidth   = 4 * DigitCount;

   localparam logic [CharWidth-1:0] ASCII_ZERO  = 8'd48;
   localparam logic [CharWidth-1:0] ASCII_NINE  = 8'd57;
   localparam logic [CharWidth-1:0] ASCII_MINUS = 8'd45;

   localparam logic KIND_SIGNED   = 1'b0;
   localparam logic KIND_UNSIGNED = 1'b1;

   typedef logic [3:0] digit_type;

endpackage

`default_nettype wire

### rtl/core/int_to_decimal_ascii.sv
`default_nettype none

// Converts a 32-bit word, read as signed or unsigned, to decimal ASCII text that leaves
// one character per rsp transfer, most significant digit first, with a leading '-' for
// negative signed values and the last mark on the final character. The block takes one
// number at a time: after a req transfer a shared add-3-and-shift step runs once per
// input bit to form ten BCD digits, leading zero digits are then dropped one per cycle
// (up to nine of them) before the output starts, and the characters follow at one per
// cycle while rsp_ready is high. Dropped zeros and digits always add up to ten, and a
// low rsp_ready stalls the output. A signed zero with precision_zero set gives no
// characters and leaves the block ready in the next cycle.
module int_to_decimal_ascii (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic                           req_kind,
   input  wire logic [itda_pkg::WordWidth-1:0] req_value,
   input  wire logic                           req_precision_zero,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic [itda_pkg::CharWidth-1:0]      rsp_character,
   output logic                                rsp_negative,
   output logic                                rsp_last
);
   import itda_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CONV = 2'd1;
   localparam logic [1:0] ST_SKIP = 2'd2;
   localparam logic [1:0] ST_EMIT = 2'd3;

   logic [1:0]           state_ff, state_in;
   logic [4:0]           bit_cnt_ff, bit_cnt_in;
   logic [3:0]           ndig_ff, ndig_in;
   logic [WordWidth-1:0] bin_ff, bin_in;
   logic [BcdWidth-1:0]  bcd_ff, bcd_in;
   logic                 neg_ff, neg_in;
   logic                 sign_ff, sign_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [CharWidth-1:0] rsp_char_ff, rsp_char_in;
   logic                 rsp_neg_ff, rsp_neg_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic [BcdWidth-1:0]  bcd_adj;
   logic [WordWidth-1:0] mag;
   logic                 is_neg;
   logic                 out_free;
   digit_type            top_digit;

   always_comb begin
      for (int i = 0; i < DigitCount; i++) begin
         if (bcd_ff[4*i +: 4] >= 4'd5) begin
            bcd_adj[4*i +: 4] = bcd_ff[4*i +: 4] + 4'd3;
         end else begin
            bcd_adj[4*i +: 4] = bcd_ff[4*i +: 4];
         end
      end
   end

   assign is_neg    = (req_kind == KIND_SIGNED) && req_value[WordWidth-1];
   assign mag       = is_neg ? (~req_value + 1'b1) : req_value;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign top_digit = bcd_ff[BcdWidth-1 -: 4];

   always_comb begin
      state_in     = state_ff;
      bit_cnt_in   = bit_cnt_ff;
      ndig_in      = ndig_ff;
      bin_in       = bin_ff;
      bcd_in       = bcd_ff;
      neg_in       = neg_ff;
      sign_in      = sign_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_char_in  = rsp_char_ff;
      rsp_neg_in   = rsp_neg_ff;
      rsp_last_in  = rsp_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               bin_in     = mag;
               bcd_in     = '0;
               neg_in     = is_neg;
               sign_in    = is_neg;
               bit_cnt_in = '0;
               ndig_in    = 4'(DigitCount);
               if (!((req_kind == KIND_SIGNED) && (req_value == '0) && req_precision_zero)) begin
                  state_in = ST_CONV;
               end
            end
         end
         ST_CONV: begin
            bcd_in     = {bcd_adj[BcdWidth-2:0], bin_ff[WordWidth-1]};
            bin_in     = {bin_ff[WordWidth-2:0], 1'b0};
            bit_cnt_in = bit_cnt_ff + 5'd1;
            if (bit_cnt_ff == 5'(WordWidth - 1)) begin
               state_in = ST_SKIP;
            end
         end
         ST_SKIP: begin
            if ((top_digit == 4'd0) && (ndig_ff > 4'd1)) begin
               bcd_in  = {bcd_ff[BcdWidth-5:0], 4'd0};
               ndig_in = ndig_ff - 4'd1;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (sign_ff) begin
                  rsp_char_in = ASCII_MINUS;
                  rsp_neg_in  = 1'b1;
                  rsp_last_in = 1'b0;
                  sign_in     = 1'b0;
               end else begin
                  rsp_char_in = ASCII_ZERO + CharWidth'(top_digit);
                  rsp_neg_in  = neg_ff;
                  rsp_last_in = (ndig_ff == 4'd1);
                  bcd_in      = {bcd_ff[BcdWidth-5:0], 4'd0};
                  ndig_in     = ndig_ff - 4'd1;
                  if (ndig_ff == 4'd1) begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         sign_ff      <= 1'b0;
         bit_cnt_ff   <= '0;
         ndig_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         sign_ff      <= sign_in;
         bit_cnt_ff   <= bit_cnt_in;
         ndig_ff      <= ndig_in;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff      <= bin_in;
      bcd_ff      <= bcd_in;
      neg_ff      <= neg_in;
      rsp_char_ff <= rsp_char_in;
      rsp_neg_ff  <= rsp_neg_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign req_ready     = (state_ff == ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_character = rsp_char_ff;
   assign rsp_negative  = rsp_neg_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

`default_nettype wire

### rtl/core/itda_checker.sv
`default_nettype none

module itda_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_ready,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic [itda_pkg::CharWidth-1:0] rsp_character,
   input wire logic                          rsp_negative,
   input wire logic                          rsp_last
);
   import itda_pkg::*;

   a_char_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_character == ASCII_MINUS) ||
                    ((rsp_character >= ASCII_ZERO) && (rsp_character <= ASCII_NINE)))
      else $error("rsp_character is not a minus sign or a digit");

   a_minus_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_character == ASCII_MINUS) |-> rsp_negative && !rsp_last)
      else $error("minus sign must be negative and never last");

   a_minus_first: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last ##1 rsp_valid |-> rsp_character != ASCII_MINUS)
      else $error("minus sign follows a character of the same number");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_character) &&
                                  $stable(rsp_negative) && $stable(rsp_last))
      else $error("stalled rsp transfer changed");

   a_ready_after_last: assert property (@(posedge clock) disable iff (reset)
      req_ready && rsp_valid |-> rsp_last)
      else $error("block is ready while a number is still being sent");

endmodule

bind int_to_decimal_ascii itda_checker u_itda_checker (.*);

`default_nettype wire
